// ----- sv/ght_pkg.sv -----
// Package for the generational handle table: widths, codes, types.
package ght_pkg;

    // Fixed field widths
    localparam int WORD_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 3;
    localparam int SLOT_COUNT_DEF = 64;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE  = 3'd0,
        CMD_DESTROY = 3'd1,
        CMD_REFRESH = 3'd2,
        CMD_DEREF   = 3'd3,
        CMD_ALIVE   = 3'd4
    } t_cmd;

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INTERNAL  = 3'd1,
        ST_INVALID   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_EXEC
    } t_state;

    // One slot entry as stored in the slot memory
    typedef struct packed {
        logic              in_use;
        logic [WORD_W-1:0] generation;
        logic [WORD_W-1:0] target;
    } t_slot;

endpackage

// ----- sv/ght_ram.sv -----
// Generic simple dual-port RAM with registered read.
module ght_ram
    import ght_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/generational_handle_table_unit.sv -----
// Top level of the generational handle table (slot map of weak references).
//
// Each command is one transfer in and one result transfer out. A command
// takes two cycles: the accept cycle issues the slot memory read, the next
// cycle checks the handle, writes the entry back and loads the result
// register. A create that reuses a freed slot takes three, since the free
// stack memory must be read before the slot memory can be addressed. The
// next command is accepted while a result waits in the output register; the
// execute cycle holds until that register is free. No clearing pass is
// needed after reset: slots at or above the high-water mark are never read,
// and a fresh slot is written in full when first taken. Configuration is a
// single bit (object store attached, reset 1) written through i_cfg_we.
module generational_handle_table_unit
    import ght_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int IDX_W = $clog2(SLOT_COUNT),
    localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    // command channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [WORD_W-1:0]   i_handle_slot,
    input  logic [WORD_W-1:0]   i_handle_generation,
    input  logic [WORD_W-1:0]   i_target,
    input  logic                i_object_live,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [WORD_W-1:0]   o_out_slot,
    output logic [WORD_W-1:0]   o_out_generation,
    output logic [WORD_W-1:0]   o_out_target,
    output logic                o_alive,
    output logic [CNT_W-1:0]    o_live_count
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SLOT_COUNT);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Control state
    t_state           r_state, n_state;
    logic             r_attached;
    logic [CNT_W-1:0] r_free_depth, r_high_water, r_live_refs;
    logic             r_out_valid;

    // Captured command
    logic [CMD_W-1:0]  r_cmd;
    logic [WORD_W-1:0] r_hslot, r_hgen, r_tgt;
    logic              r_live;
    logic [IDX_W-1:0]  r_idx, n_idx;

    // Result register
    logic [STATUS_W-1:0] r_status;
    logic [WORD_W-1:0]   r_oslot, r_ogen, r_otgt;
    logic                r_oalive;
    logic [CNT_W-1:0]    r_ocount;

    // Memory ports
    logic             slot_we;
    t_slot            slot_wdata, slot_rdata;
    logic [IDX_W-1:0] slot_raddr;
    logic             stk_we;
    logic [IDX_W-1:0] stk_raddr, stk_rdata;
    logic [CNT_W-1:0] depth_m1;

    // Handshake and sequencing
    logic in_xfer, advance, pop_now;

    // Execute-cycle results
    t_status          x_status;
    logic [WORD_W-1:0] x_oslot, x_ogen, x_otgt;
    logic             x_oalive;
    logic             x_hw_inc, x_fd_dec, x_fd_inc, x_lr_inc, x_lr_dec;
    logic             valid_h, x_pop;
    logic [WORD_W-1:0] x_gen;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign advance  = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign depth_m1 = r_free_depth - CNT_ONE;
    assign stk_raddr = depth_m1[IDX_W-1:0];

    // A create that can succeed and has a freed slot to reuse
    assign pop_now = (t_cmd'(i_command) == CMD_CREATE) && r_attached
                     && (i_target != '0) && i_object_live && (r_free_depth != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = pop_now ? S_POP : S_EXEC;
                end
            end
            S_POP:  n_state = S_EXEC;
            S_EXEC: begin
                if (advance) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: stall, slot read address, index capture
    always_comb begin
        o_in_stall = 1'b1;
        slot_raddr = i_handle_slot[IDX_W-1:0];
        n_idx      = r_idx;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (t_cmd'(i_command) == CMD_CREATE) begin
                    n_idx = r_high_water[IDX_W-1:0];
                end else begin
                    n_idx = i_handle_slot[IDX_W-1:0];
                end
            end
            S_POP: begin
                slot_raddr = stk_rdata;
                n_idx      = stk_rdata;
            end
            S_EXEC:  slot_raddr = r_idx;
            default: slot_raddr = r_idx;
        endcase
    end

    // Handle check against the entry read back
    assign valid_h = !((r_hslot == '0) && (r_hgen == '0))
                     && (r_hslot < WORD_W'(r_high_water))
                     && slot_rdata.in_use && (slot_rdata.generation == r_hgen);

    assign x_pop = (r_free_depth != '0);
    assign x_gen = x_pop ? (slot_rdata.generation + WORD_W'(1)) : WORD_W'(1);

    // Execute: command decode, entry write-back, result
    always_comb begin
        x_status   = ST_OK;
        x_oslot    = '0;
        x_ogen     = '0;
        x_otgt     = '0;
        x_oalive   = 1'b0;
        x_hw_inc   = 1'b0;
        x_fd_dec   = 1'b0;
        x_fd_inc   = 1'b0;
        x_lr_inc   = 1'b0;
        x_lr_dec   = 1'b0;
        slot_we    = 1'b0;
        stk_we     = 1'b0;
        slot_wdata = slot_rdata;
        case (r_cmd)
            CMD_CREATE: begin
                if (!r_attached) begin
                    x_status = ST_INTERNAL;
                end else if ((r_tgt == '0) || !r_live) begin
                    x_status = ST_INVALID;
                end else if (!x_pop && (r_high_water >= CNT_MAX)) begin
                    x_status = ST_FULL;
                end else begin
                    x_fd_dec   = x_pop;
                    x_hw_inc   = !x_pop;
                    x_lr_inc   = (r_live_refs < CNT_MAX);
                    slot_we    = 1'b1;
                    slot_wdata = '{in_use: 1'b1, generation: x_gen, target: r_tgt};
                    x_oslot    = WORD_W'(r_idx);
                    x_ogen     = x_gen;
                end
            end
            CMD_DESTROY: begin
                if (!valid_h) begin
                    x_status = ST_NOT_FOUND;
                end else begin
                    x_lr_dec          = (r_live_refs != '0);
                    slot_we           = 1'b1;
                    slot_wdata.in_use = 1'b0;
                    slot_wdata.target = '0;
                    stk_we            = (r_free_depth < CNT_MAX);
                    x_fd_inc          = (r_free_depth < CNT_MAX);
                end
            end
            CMD_REFRESH: begin
                if (!r_attached) begin
                    x_status = ST_INTERNAL;
                end else if (!valid_h) begin
                    x_status = ST_NOT_FOUND;
                end else if ((r_tgt != '0) && !r_live) begin
                    x_status = ST_INVALID;
                end else begin
                    slot_we           = 1'b1;
                    slot_wdata.target = r_tgt;
                end
            end
            CMD_DEREF: begin
                if (!r_attached) begin
                    x_status = ST_INTERNAL;
                end else if (!valid_h) begin
                    x_status = ST_NOT_FOUND;
                end else if (slot_rdata.target != '0) begin
                    if (r_live) begin
                        x_otgt   = slot_rdata.target;
                        x_oalive = 1'b1;
                    end else begin
                        slot_we           = 1'b1;
                        slot_wdata.target = '0;
                    end
                end
            end
            CMD_ALIVE: begin
                x_oalive = r_attached && valid_h && (slot_rdata.target != '0) && r_live;
            end
            default: x_status = ST_INVALID;
        endcase
        // writes land only on the cycle the result is loaded
        slot_we = slot_we && advance;
        stk_we  = stk_we && advance;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_attached   <= 1'b1;
            r_free_depth <= '0;
            r_high_water <= '0;
            r_live_refs  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_attached <= i_cfg_wdata;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                if (x_hw_inc) r_high_water <= r_high_water + CNT_ONE;
                if (x_fd_dec) r_free_depth <= depth_m1;
                if (x_fd_inc) r_free_depth <= r_free_depth + CNT_ONE;
                if (x_lr_inc) r_live_refs  <= r_live_refs + CNT_ONE;
                if (x_lr_dec) r_live_refs  <= r_live_refs - CNT_ONE;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command capture and result register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd   <= i_command;
            r_hslot <= i_handle_slot;
            r_hgen  <= i_handle_generation;
            r_tgt   <= i_target;
            r_live  <= i_object_live;
        end
        r_idx <= n_idx;
        if (advance) begin
            r_status <= x_status;
            r_oslot  <= x_oslot;
            r_ogen   <= x_ogen;
            r_otgt   <= x_otgt;
            r_oalive <= x_oalive;
            if (x_lr_inc) begin
                r_ocount <= r_live_refs + CNT_ONE;
            end else if (x_lr_dec) begin
                r_ocount <= r_live_refs - CNT_ONE;
            end else begin
                r_ocount <= r_live_refs;
            end
        end
    end

    // Slot entries: in-use flag, generation, target
    ght_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (r_idx),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // LIFO of freed slot numbers
    ght_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOT_COUNT)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_free_depth[IDX_W-1:0]),
        .i_wdata (r_idx),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_out_slot       = r_oslot;
    assign o_out_generation = r_ogen;
    assign o_out_target     = r_otgt;
    assign o_alive          = r_oalive;
    assign o_live_count     = r_ocount;

endmodule

// ----- test/handle_table_checker.sv -----
// Result checker for the handle table: tracks table state, predicts each result, compares.
`timescale 1ns / 1ps

module handle_table_checker
    import ght_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [WORD_W-1:0]   i_handle_slot,
    input  logic [WORD_W-1:0]   i_handle_generation,
    input  logic [WORD_W-1:0]   i_target,
    input  logic                i_object_live,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [WORD_W-1:0]   i_out_slot,
    input  logic [WORD_W-1:0]   i_out_generation,
    input  logic [WORD_W-1:0]   i_out_target,
    input  logic                i_alive,
    input  logic [CNT_W-1:0]    i_live_count,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        t_status           status;
        logic [WORD_W-1:0] slot;
        logic [WORD_W-1:0] generation;
        logic [WORD_W-1:0] target;
        logic              alive;
        logic [CNT_W-1:0]  live_count;
    } t_answer;

    // Shadow copy of the table
    bit              store_attached;
    bit              slot_busy [SLOT_COUNT];
    bit [WORD_W-1:0] slot_gen [SLOT_COUNT];
    bit [WORD_W-1:0] slot_obj [SLOT_COUNT];
    int unsigned     free_slots [SLOT_COUNT];
    int unsigned     free_top;
    int unsigned     high_mark;
    int unsigned     busy_count;

    t_answer results_due [$];
    int      fail_count = 0;

    task automatic clear_table();
        store_attached = 1'b1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_busy[i]  = 1'b0;
            slot_gen[i]   = '0;
            slot_obj[i]   = '0;
            free_slots[i] = 0;
        end
        free_top   = 0;
        high_mark  = 0;
        busy_count = 0;
    endtask

    // Slot index of a valid handle, or -1
    function automatic int locate_slot(logic [WORD_W-1:0] hslot, logic [WORD_W-1:0] hgen);
        if (hslot == '0 && hgen == '0) return -1;
        if (hslot >= high_mark) return -1;
        if (!slot_busy[hslot] || slot_gen[hslot] != hgen) return -1;
        return int'(hslot);
    endfunction

    // Apply one command to the shadow table and return the answer it gives
    function automatic t_answer run_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] hslot,
                                            logic [WORD_W-1:0] hgen, logic [WORD_W-1:0] tgt,
                                            logic live);
        t_answer     a;
        int          s;
        int unsigned idx;
        a = '0;
        a.status = ST_OK;
        case (cmd)
            CMD_CREATE: begin
                if (!store_attached) begin
                    a.status = ST_INTERNAL;
                end else if (tgt == '0 || !live) begin
                    a.status = ST_INVALID;
                end else if (free_top > 0 || high_mark < SLOT_COUNT) begin
                    // LIFO reuse first, else a fresh slot
                    if (free_top > 0) begin
                        free_top--;
                        idx = free_slots[free_top];
                        slot_gen[idx] = slot_gen[idx] + 1'b1;
                    end else begin
                        idx = high_mark;
                        high_mark++;
                        slot_gen[idx] = 1;
                    end
                    slot_busy[idx] = 1'b1;
                    slot_obj[idx]  = tgt;
                    if (busy_count < SLOT_COUNT) busy_count++;
                    a.slot       = idx;
                    a.generation = slot_gen[idx];
                end else begin
                    a.status = ST_FULL;
                end
            end
            CMD_DESTROY: begin
                s = locate_slot(hslot, hgen);
                if (s < 0) begin
                    a.status = ST_NOT_FOUND;
                end else begin
                    if (busy_count > 0) busy_count--;
                    slot_busy[s] = 1'b0;
                    slot_obj[s]  = '0;
                    if (free_top < SLOT_COUNT) begin
                        free_slots[free_top] = s;
                        free_top++;
                    end
                end
            end
            CMD_REFRESH: begin
                s = locate_slot(hslot, hgen);
                if (!store_attached) a.status = ST_INTERNAL;
                else if (s < 0) a.status = ST_NOT_FOUND;
                else if (tgt != '0 && !live) a.status = ST_INVALID;
                else slot_obj[s] = tgt;
            end
            CMD_DEREF: begin
                s = locate_slot(hslot, hgen);
                if (!store_attached) begin
                    a.status = ST_INTERNAL;
                end else if (s < 0) begin
                    a.status = ST_NOT_FOUND;
                end else if (slot_obj[s] != '0) begin
                    // live target is returned, dead one is dropped
                    if (live) begin
                        a.target = slot_obj[s];
                        a.alive  = 1'b1;
                    end else begin
                        slot_obj[s] = '0;
                    end
                end
            end
            CMD_ALIVE: begin
                s = locate_slot(hslot, hgen);
                if (store_attached && s >= 0 && slot_obj[s] != '0 && live) a.alive = 1'b1;
            end
            default: a.status = ST_INVALID;
        endcase
        a.live_count = CNT_W'(busy_count);
        return a;
    endfunction

    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Watch both channels; results are matched before new commands are queued
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            clear_table();
            results_due.delete();
        end else begin
            if (i_cfg_we) store_attached = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", WORD_W'(want.status), WORD_W'(i_status));
                    check_field("out_slot", want.slot, i_out_slot);
                    check_field("out_generation", want.generation, i_out_generation);
                    check_field("out_target", want.target, i_out_target);
                    check_field("alive", WORD_W'(want.alive), WORD_W'(i_alive));
                    check_field("live_count", WORD_W'(want.live_count),
                                WORD_W'(i_live_count));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                results_due = {results_due, run_command(i_command, i_handle_slot,
                                                        i_handle_generation, i_target,
                                                        i_object_live)};
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= results_due.size();
    end

endmodule

// ----- test/generational_handle_table_unit_test.sv -----
// Testbench top for the handle table: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module generational_handle_table_unit_test
    import ght_pkg::*;
();

    localparam int CNT_W          = $clog2(SLOT_COUNT_DEF + 1);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int POOL_MAX       = 96;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    logic i_in_valid = 1'b0;
    logic [CMD_W-1:0] i_command = '0;
    logic [WORD_W-1:0] i_handle_slot = '0;
    logic [WORD_W-1:0] i_handle_generation = '0;
    logic [WORD_W-1:0] i_target = '0;
    logic i_object_live = 1'b0;
    logic i_out_stall = 1'b0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [WORD_W-1:0]   o_out_slot;
    logic [WORD_W-1:0]   o_out_generation;
    logic [WORD_W-1:0]   o_out_target;
    logic                o_alive;
    logic [CNT_W-1:0]    o_live_count;

    int fail_total;
    int pending;

    // Stimulus control shared with the receiver
    bit quiet = 1'b0;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;

    // Handles seen coming back from creates, {generation, slot}
    logic [63:0] handle_pool [$];
    int cmd_seen [8];
    int full_hits = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    generational_handle_table_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_command           (i_command),
        .i_handle_slot       (i_handle_slot),
        .i_handle_generation (i_handle_generation),
        .i_target            (i_target),
        .i_object_live       (i_object_live),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_out_slot          (o_out_slot),
        .o_out_generation    (o_out_generation),
        .o_out_target        (o_out_target),
        .o_alive             (o_alive),
        .o_live_count        (o_live_count)
    );

    handle_table_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_command           (i_command),
        .i_handle_slot       (i_handle_slot),
        .i_handle_generation (i_handle_generation),
        .i_target            (i_target),
        .i_object_live       (i_object_live),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_status            (o_status),
        .i_out_slot          (o_out_slot),
        .i_out_generation    (o_out_generation),
        .i_out_target        (o_out_target),
        .i_alive             (o_alive),
        .i_live_count        (o_live_count),
        .o_fail_count        (fail_total),
        .o_pending           (pending)
    );

    // Result receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_served != hold_asks) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = !quiet && ($urandom_range(1, 100) <= 15);
        end
    end

    // Collect new handles and table-full answers from result transfers
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (o_status == ST_OK && o_out_generation != '0) begin
                handle_pool = {handle_pool, {o_out_generation, o_out_slot}};
                if (handle_pool.size() > POOL_MAX) void'(handle_pool.pop_front());
            end
            if (o_status == ST_FULL) full_hits++;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one command and hold it until the transfer; called at a falling edge
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] hslot,
                            logic [WORD_W-1:0] hgen, logic [WORD_W-1:0] tgt, logic live);
        while (!quiet && $urandom_range(1, 100) <= 15) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_command           = cmd;
        i_handle_slot       = hslot;
        i_handle_generation = hgen;
        i_target            = tgt;
        i_object_live       = live;
        i_in_valid          = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        cmd_seen[cmd]++;
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_attached(logic value);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cfg_writes++;
    endtask

    // Random command with weighted mix; unknown codes take what is left of 100
    task automatic send_random(int w_create, int w_destroy, int w_refresh, int w_deref,
                               int w_alive);
        logic [CMD_W-1:0]  cmd;
        logic [63:0]       h;
        logic [WORD_W-1:0] tgt;
        int                r;
        int                p;
        r = $urandom_range(0, 99);
        if (r < w_create) cmd = CMD_CREATE;
        else if (r < w_create + w_destroy) cmd = CMD_DESTROY;
        else if (r < w_create + w_destroy + w_refresh) cmd = CMD_REFRESH;
        else if (r < w_create + w_destroy + w_refresh + w_deref) cmd = CMD_DEREF;
        else if (r < w_create + w_destroy + w_refresh + w_deref + w_alive) cmd = CMD_ALIVE;
        else cmd = CMD_W'($urandom_range(5, 7));
        p = $urandom_range(0, 99);
        if (p < 75 && handle_pool.size() > 0)
            h = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
        else if (p < 85)
            h = {$urandom(), $urandom()};
        else if (p < 95)
            h = {32'($urandom_range(0, 3)), 32'($urandom_range(0, SLOT_COUNT_DEF + 1))};
        else
            h = '0;
        tgt = ($urandom_range(0, 99) < 12) ? '0 : $urandom();
        send_cmd(cmd, h[31:0], h[63:32], tgt, $urandom_range(0, 99) < 80);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        write_attached(1'b1);

        // Directed: argument checks, target lifecycle, LIFO reuse, bad handles
        send_cmd(CMD_CREATE, '0, '0, '0, 1'b1);
        send_cmd(CMD_CREATE, '0, '0, 32'h1234_5678, 1'b0);
        send_cmd(CMD_CREATE, '0, '0, 32'hFFFF_FFFF, 1'b1);
        send_cmd(CMD_CREATE, '0, '0, 32'h1234_5678, 1'b1);
        send_cmd(CMD_ALIVE, 32'd0, 32'd1, '0, 1'b1);
        send_cmd(CMD_ALIVE, 32'd0, 32'd1, '0, 1'b0);
        send_cmd(CMD_DEREF, 32'd0, 32'd1, '0, 1'b1);
        send_cmd(CMD_REFRESH, 32'd0, 32'd1, 32'h1234_5678, 1'b0);
        send_cmd(CMD_REFRESH, 32'd0, 32'd1, 32'h1234_5678, 1'b1);
        send_cmd(CMD_DEREF, 32'd0, 32'd1, '0, 1'b0);
        send_cmd(CMD_DEREF, 32'd0, 32'd1, '0, 1'b1);
        send_cmd(CMD_REFRESH, 32'd1, 32'd1, '0, 1'b0);
        send_cmd(CMD_ALIVE, 32'd1, 32'd1, '0, 1'b1);
        send_cmd(CMD_DESTROY, 32'd0, 32'd1, '0, 1'b1);
        send_cmd(CMD_DESTROY, 32'd0, 32'd1, '0, 1'b1);
        send_cmd(CMD_CREATE, '0, '0, 32'h0000_0001, 1'b1);
        send_cmd(CMD_DEREF, 32'd0, 32'd1, '0, 1'b1);
        send_cmd(CMD_DEREF, 32'd0, 32'd0, '0, 1'b1);
        send_cmd(CMD_ALIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(CMD_DESTROY, 32'hFFFF_FFFF, 32'd1, '0, 1'b1);
        send_cmd(CMD_REFRESH, 32'd2, 32'd1, 32'h1234_5678, 1'b1);
        for (int c = 5; c < 8; c++) send_cmd(CMD_W'(c), $urandom(), $urandom(), $urandom(), 1'b1);

        // Object store detached
        write_attached(1'b0);
        repeat (40) send_random(20, 15, 20, 20, 22);

        // Create-heavy, runs into a full table
        write_attached(1'b1);
        repeat (150) send_random(65, 5, 10, 10, 7);

        // Balanced mix with no idling on either side
        drain();
        quiet = 1'b1;
        repeat (150) send_random(25, 20, 17, 17, 18);
        quiet = 1'b0;

        // Destroy-heavy while the receiver holds off
        hold_asks++;
        repeat (130) send_random(10, 45, 14, 14, 14);

        drain();
        repeat (110) send_random(30, 25, 14, 14, 14);

        drain();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d create, %0d destroy, %0d refresh, %0d deref, %0d alive commands",
                 cmd_seen[CMD_CREATE], cmd_seen[CMD_DESTROY], cmd_seen[CMD_REFRESH],
                 cmd_seen[CMD_DEREF], cmd_seen[CMD_ALIVE]);
        $display("plus %0d unknown codes; %0d table-full answers; %0d config writes",
                 cmd_seen[5] + cmd_seen[6] + cmd_seen[7], full_hits, cfg_writes);
        if (fail_total == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
